FILE: hw/rtl/lpdfp_pkg.sv
// ----------------------------------------------------------------------------
// lpdfp_pkg
// Shared types and constants for the downlink frame parser: frame layout,
// message type codes, status codes, register map and inter-module structs.
// ----------------------------------------------------------------------------
package lpdfp_pkg;

  // Frame layout.
  localparam int unsigned MAX_FRAME_BYTES = 255;
  localparam logic [7:0]  POS_MHDR        = 8'd0;
  localparam logic [7:0]  POS_ADDR_LAST   = 8'd4;
  localparam logic [7:0]  POS_FCTRL       = 8'd5;
  localparam logic [7:0]  POS_FCNT_LO     = 8'd6;
  localparam logic [7:0]  POS_FCNT_HI     = 8'd7;
  localparam logic [7:0]  POS_FPORT_BASE  = 8'd8;
  // Header, FPort and check word together; FOpts length comes on top.
  localparam logic [7:0]  MIN_FRAME_BYTES = 8'd13;

  // MHDR message type codes.
  localparam logic [7:0] TYPE_MASK        = 8'hE0;
  localparam logic [7:0] TYPE_UNCONF_DOWN = 8'h60;
  localparam logic [7:0] TYPE_CONF_DOWN   = 8'hA0;
  localparam logic [7:0] FOPTS_LEN_MASK   = 8'h0F;

  // End-of-frame status codes.
  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_TYPE  = 3'd1,
    ST_ADDR  = 3'd2,
    ST_CHECK = 3'd3,
    ST_PORT  = 3'd4,
    ST_SHORT = 3'd5
  } status_e;

  // Output item kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // Register map, indexed by paddr[3:2].
  typedef enum logic [1:0] {
    REG_DEV_ADDR   = 2'd0,
    REG_APP_PORT   = 2'd1,
    REG_CHECK_WORD = 2'd2
  } reg_idx_e;

  localparam int unsigned PADDR_W = 4;

  localparam logic [31:0] DEV_ADDR_RST   = 32'h1122_3344;
  localparam logic [7:0]  APP_PORT_RST   = 8'd88;
  localparam logic [31:0] CHECK_WORD_RST = 32'h1234_5678;

  // Configuration seen by the parse core.
  typedef struct packed {
    logic [31:0] dev_addr;
    logic [7:0]  app_port;
    logic [31:0] check_word;
  } cfg_t;

  // One result produced by the parse core for one byte.
  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [7:0]  data;
    logic [2:0]  status;
    logic [31:0] dl_count;
    logic [7:0]  pay_len;
  } res_t;

endpackage

FILE: hw/rtl/lpwan_downlink_frame_parser.sv
// ----------------------------------------------------------------------------
// lpwan_downlink_frame_parser
// A byte's beat is captured in the input register, and its result is then
// registered in the result register, which drives out_valid.
// Throughput: one byte per cycle, set by the input register feeding the parse
// core and result register; the input side keeps taking beats while a result
// waits, as long as the result register frees up in the same cycle.
// Reset: asynchronous and active low; parse state, counter and valids clear,
// registers return to their defaults.
// ----------------------------------------------------------------------------
module lpwan_downlink_frame_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Byte input channel.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    rx_byte_i,
  input  logic                          frame_end_i,
  // Result output channel.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          item_kind_o,
  output logic [7:0]                    data_byte_o,
  output logic [2:0]                    frame_status_o,
  output logic [31:0]                   downlink_count_o,
  output logic [7:0]                    payload_length_o,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lpdfp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import lpdfp_pkg::*;

  cfg_t        cfg;
  res_t        res;

  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic        fire;

  logic        out_valid_q;
  logic        kind_q;
  logic [7:0]  data_q;
  logic [2:0]  status_q;
  logic [31:0] dlcnt_q;
  logic [7:0]  plen_q;

  // Configuration registers.
  lpdfp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // A held byte is processed when the result register can take its result.
  assign fire       = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | fire;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
      last_q <= frame_end_i;
    end
  end

  // Parse core.
  lpdfp_parse_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (fire),
    .byte_i (byte_q),
    .last_i (last_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res.valid) begin
      kind_q   <= res.kind;
      data_q   <= res.data;
      status_q <= res.status;
      dlcnt_q  <= res.dl_count;
      plen_q   <= res.pay_len;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign item_kind_o      = kind_q;
  assign data_byte_o      = data_q;
  assign frame_status_o   = status_q;
  assign downlink_count_o = dlcnt_q;
  assign payload_length_o = plen_q;

endmodule

FILE: hw/rtl/lpdfp_cfg_regs.sv
// ----------------------------------------------------------------------------
// lpdfp_cfg_regs
// APB-style register block holding device address, application port and
// expected check word. Writes complete in the access phase; pready is tied high.
// ----------------------------------------------------------------------------
module lpdfp_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lpdfp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output lpdfp_pkg::cfg_t              cfg_o
);
  import lpdfp_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register writes; an address past the map is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_addr   <= DEV_ADDR_RST;
      cfg_q.app_port   <= APP_PORT_RST;
      cfg_q.check_word <= CHECK_WORD_RST;
    end else if (wr_en) begin
      case (idx)
        REG_DEV_ADDR:   cfg_q.dev_addr   <= pwdata;
        REG_APP_PORT:   cfg_q.app_port   <= pwdata[7:0];
        REG_CHECK_WORD: cfg_q.check_word <= pwdata;
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    case (idx)
      REG_DEV_ADDR:   prdata = cfg_q.dev_addr;
      REG_APP_PORT:   prdata = {24'd0, cfg_q.app_port};
      REG_CHECK_WORD: prdata = cfg_q.check_word;
      default:        prdata = 32'd0;
    endcase
  end

endmodule

FILE: hw/rtl/lpdfp_parse_core.sv
// ----------------------------------------------------------------------------
// lpdfp_parse_core
// Per-frame parse state and the combinational next-state logic. Each step takes
// one byte, updates field capture, the 4-byte tail delay and the counters, and
// produces at most one result. The downlink counter persists across frames.
// ----------------------------------------------------------------------------
module lpdfp_parse_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      byte_i,
  input  logic            last_i,
  input  lpdfp_pkg::cfg_t cfg_i,
  output lpdfp_pkg::res_t res_o
);
  import lpdfp_pkg::*;

  logic [7:0]  pos_q, pos_d;
  logic        type_ok_q, type_ok_d;
  logic [31:0] addr_q, addr_d;
  logic [3:0]  optlen_q, optlen_d;
  logic [15:0] rcnt_q, rcnt_d;
  status_e     err_q, err_d;
  logic [7:0]  tail_q [4];
  logic [7:0]  tail_d [4];
  logic [7:0]  pcnt_q, pcnt_d;
  logic [31:0] dlcnt_q, dlcnt_d;

  logic        kept;
  logic        released;
  logic [7:0]  rel_byte;
  logic [7:0]  mtype;
  logic [31:0] check;
  logic [7:0]  need_len;
  logic [15:0] diff;
  status_e     status;

  assign kept  = pos_q < 8'(MAX_FRAME_BYTES);
  assign mtype = byte_i & TYPE_MASK;

  always_comb begin
    pos_d     = pos_q;
    type_ok_d = type_ok_q;
    addr_d    = addr_q;
    optlen_d  = optlen_q;
    rcnt_d    = rcnt_q;
    err_d     = err_q;
    tail_d    = tail_q;
    pcnt_d    = pcnt_q;
    dlcnt_d   = dlcnt_q;
    released  = 1'b0;
    rel_byte  = tail_q[0];

    // Field capture, tail delay and payload release for a kept byte.
    if (kept) begin
      if (pos_q == POS_MHDR) begin
        type_ok_d = (mtype == TYPE_UNCONF_DOWN) || (mtype == TYPE_CONF_DOWN);
        if (!type_ok_d) begin
          err_d = ST_TYPE;
        end
      end else if (pos_q <= POS_ADDR_LAST) begin
        addr_d = {byte_i, addr_q[31:8]};
        if (pos_q == POS_ADDR_LAST && err_q == ST_OK && addr_d != cfg_i.dev_addr) begin
          err_d = ST_ADDR;
        end
      end else if (pos_q == POS_FCTRL) begin
        optlen_d = byte_i[3:0] & FOPTS_LEN_MASK[3:0];
      end else if (pos_q == POS_FCNT_LO) begin
        rcnt_d = {8'd0, byte_i};
      end else if (pos_q == POS_FCNT_HI) begin
        rcnt_d = {byte_i, rcnt_q[7:0]};
      end else if (pos_q == POS_FPORT_BASE + {4'd0, optlen_q}) begin
        if (err_q == ST_OK && byte_i != cfg_i.app_port) begin
          err_d = ST_PORT;
        end
      end

      tail_d[0] = tail_q[1];
      tail_d[1] = tail_q[2];
      tail_d[2] = tail_q[3];
      tail_d[3] = byte_i;

      if (pos_q >= MIN_FRAME_BYTES + {4'd0, optlen_d} && type_ok_d && err_d == ST_OK) begin
        released = 1'b1;
        if (pcnt_q != 8'hFF) begin
          pcnt_d = pcnt_q + 8'd1;
        end
      end
      pos_d = pos_q + 8'd1;
    end

    // End-of-frame judgment, in order of precedence.
    check    = {tail_d[3], tail_d[2], tail_d[1], tail_d[0]};
    need_len = MIN_FRAME_BYTES + {4'd0, optlen_d};
    if (!type_ok_d) begin
      status = ST_TYPE;
    end else if (pos_d < need_len) begin
      status = ST_SHORT;
    end else if (err_d == ST_ADDR) begin
      status = ST_ADDR;
    end else if (check != cfg_i.check_word) begin
      status = ST_CHECK;
    end else if (err_d == ST_PORT) begin
      status = ST_PORT;
    end else begin
      status = ST_OK;
    end

    // Extend FCnt into the stored counter; both directions add the 16-bit diff.
    diff = rcnt_d - dlcnt_q[15:0];
    if (last_i && (status == ST_OK || status == ST_PORT)) begin
      dlcnt_d = dlcnt_q + {16'd0, diff};
    end

    // Result item.
    res_o.valid    = last_i | released;
    res_o.kind     = last_i ? KIND_STATUS : KIND_PAYLOAD;
    res_o.data     = released ? rel_byte : 8'd0;
    res_o.status   = last_i ? status : ST_OK;
    res_o.dl_count = dlcnt_d;
    res_o.pay_len  = pcnt_d;

    // Frame end returns per-frame state to its reset value.
    if (last_i) begin
      pos_d     = 8'd0;
      type_ok_d = 1'b0;
      addr_d    = 32'd0;
      optlen_d  = 4'd0;
      rcnt_d    = 16'd0;
      err_d     = ST_OK;
      tail_d[0] = 8'd0;
      tail_d[1] = 8'd0;
      tail_d[2] = 8'd0;
      tail_d[3] = 8'd0;
      pcnt_d    = 8'd0;
    end
  end

  // Parse state registers, advanced once per processed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= 8'd0;
      type_ok_q <= 1'b0;
      addr_q    <= 32'd0;
      optlen_q  <= 4'd0;
      rcnt_q    <= 16'd0;
      err_q     <= ST_OK;
      tail_q[0] <= 8'd0;
      tail_q[1] <= 8'd0;
      tail_q[2] <= 8'd0;
      tail_q[3] <= 8'd0;
      pcnt_q    <= 8'd0;
      dlcnt_q   <= 32'd0;
    end else if (step_i) begin
      pos_q     <= pos_d;
      type_ok_q <= type_ok_d;
      addr_q    <= addr_d;
      optlen_q  <= optlen_d;
      rcnt_q    <= rcnt_d;
      err_q     <= err_d;
      tail_q    <= tail_d;
      pcnt_q    <= pcnt_d;
      dlcnt_q   <= dlcnt_d;
    end
  end

endmodule

FILE: hw/rtl/lpdfp_checker.sv
// ----------------------------------------------------------------------------
// lpdfp_checker
// Port-level checks for the downlink frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module lpdfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        item_kind_o,
  input logic [7:0]  data_byte_o,
  input logic [2:0]  frame_status_o,
  input logic [31:0] downlink_count_o,
  input logic [7:0]  payload_length_o,
  input logic        pready
);
  import lpdfp_pkg::*;

  // The register port never inserts wait states.
  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

  // A payload beat carries an OK status.
  a_payload_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && item_kind_o == KIND_PAYLOAD) |-> frame_status_o == ST_OK)
    else $error("payload beat with nonzero status");

  // A payload beat counts itself in the payload length.
  a_payload_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && item_kind_o == KIND_PAYLOAD) |-> payload_length_o != 8'd0)
    else $error("payload beat with zero length");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> frame_status_o <= ST_SHORT)
    else $error("undefined frame status");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(data_byte_o)
      && $stable(item_kind_o) && $stable(downlink_count_o)
      && $stable(payload_length_o)))
    else $error("stalled result changed");

endmodule

bind lpwan_downlink_frame_parser lpdfp_checker u_lpdfp_checker (.*);
